[rtl/trmf_pkg.sv]
package trmf_pkg;

    localparam int RPM_W    = 16;
    localparam int FACTOR_W = 8;
    localparam int PROD_W   = RPM_W + FACTOR_W;

    localparam logic [RPM_W-1:0]    RPM_MAX    = 16'hFFFF;
    localparam logic [RPM_W-1:0]    CNT_MAX    = 16'hFFFF;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd30;

    // link handed from one cell to its right neighbour
    typedef struct packed {
        logic le;       // this cell's remaining value is <= new value
        logic rm_seen;  // the oldest entry sits at or left of this cell
    } t_link;

    // measurement status after a beat has been applied
    typedef struct packed {
        logic [RPM_W-1:0] latest;
        logic             stalled;
        logic             fresh;
    } t_status;

    typedef struct packed {
        logic [RPM_W-1:0] latest;
        logic [RPM_W-1:0] median;
        logic             stalled;
        logic             fresh;
    } t_result;

endpackage

[rtl/tacho_rpm_median_filter_unit.sv]
// an accepted beat's result is registered in the output queue, shown when it reaches r_q0
// throughput: one beat per clock while the output queue has room; the whole window updates
//   through the sorted cell row combinationally, so only a full output queue holds the input
// the two-entry output queue still takes a beat while one result is held back
// reset (i_rst_n, synchronous, active low): counter, flags and latest rpm cleared,
//   window filled with zeros, factor back to 30, output queue emptied
module tacho_rpm_median_filter_unit #(
    parameter int WINDOW = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [trmf_pkg::FACTOR_W-1:0]     i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_tacho_edge,
    input  logic                              i_period_end,
    input  logic                              i_read_ack,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [trmf_pkg::RPM_W-1:0]        o_latest_rpm,
    output logic [trmf_pkg::RPM_W-1:0]        o_median_rpm,
    output logic                              o_stalled,
    output logic                              o_fresh
);

    localparam int AGE_W = $clog2(WINDOW);
    localparam int MID   = WINDOW / 2;

    logic                       w_push;
    logic                       w_pop;
    logic                       w_ins;
    logic [trmf_pkg::RPM_W-1:0] w_rpm;
    trmf_pkg::t_status          w_next;
    trmf_pkg::t_result          w_result;

    // cell row; index 0 is the tie-off on the left end and index WINDOW on the right end
    trmf_pkg::t_link            w_link    [WINDOW+1];
    logic [trmf_pkg::RPM_W-1:0] w_u_value [WINDOW+1];
    logic [AGE_W-1:0]           w_u_age   [WINDOW+1];
    logic [trmf_pkg::RPM_W-1:0] w_value   [WINDOW+1];
    logic [AGE_W-1:0]           w_age     [WINDOW+1];
    logic [trmf_pkg::RPM_W-1:0] w_n_value [WINDOW];
    logic [WINDOW-1:0]          w_oldest;
    logic [WINDOW-2:0]          w_order;

    // output queue: r_q0 is the head shown on the ports
    trmf_pkg::t_result r_q0;
    trmf_pkg::t_result r_q1;
    logic [1:0]        r_cnt;

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign w_push = i_in_valid & o_in_ready;
    assign w_pop  = o_out_valid & i_out_ready;
    assign w_ins  = w_push & i_period_end;

    trmf_meas u_meas (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_take       (w_push),
        .i_tacho_edge (i_tacho_edge),
        .i_period_end (i_period_end),
        .i_read_ack   (i_read_ack),
        .o_rpm        (w_rpm),
        .o_next       (w_next)
    );

    // left end: new value may always land in cell 0, nothing removed yet
    assign w_link[0].le      = 1'b1;
    assign w_link[0].rm_seen = 1'b0;
    assign w_u_value[0]      = '0;
    assign w_u_age[0]        = '0;
    // right end: nothing beyond the last cell
    assign w_value[WINDOW]   = '0;
    assign w_age[WINDOW]     = '0;

    // cells are sorted ascending; each holds one window entry and its age
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        trmf_cell #(
            .WINDOW (WINDOW),
            .AGE_W  (AGE_W),
            .INDEX  (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ins          (w_ins),
            .i_x            (w_rpm),
            .i_link         (w_link[g]),
            .i_left_u_value (w_u_value[g]),
            .i_left_u_age   (w_u_age[g]),
            .i_right_value  (w_value[g+1]),
            .i_right_age    (w_age[g+1]),
            .o_link         (w_link[g+1]),
            .o_u_value      (w_u_value[g+1]),
            .o_u_age        (w_u_age[g+1]),
            .o_value        (w_value[g]),
            .o_age          (w_age[g]),
            .o_n_value      (w_n_value[g])
        );
        assign w_oldest[g] = (w_age[g] == AGE_W'(WINDOW - 1));
    end

    for (genvar g = 0; g < WINDOW - 1; g++) begin : g_order
        assign w_order[g] = (w_value[g] <= w_value[g+1]);
    end

    // median is the middle cell after this beat's insertion
    assign w_result.latest  = w_next.latest;
    assign w_result.median  = w_n_value[MID];
    assign w_result.stalled = w_next.stalled;
    assign w_result.fresh   = w_next.fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            priority if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop)) begin
            if (w_push) begin
                r_q0 <= w_result;
            end
        end else if (r_cnt == 2'd1) begin
            if (w_push) begin
                r_q1 <= w_result;
            end
        end else begin
            if (w_pop) begin
                r_q0 <= r_q1;
            end
        end
    end

    assign o_latest_rpm = r_q0.latest;
    assign o_median_rpm = r_q0.median;
    assign o_stalled    = r_q0.stalled;
    assign o_fresh      = r_q0.fresh;

    // exactly one entry of the window is the oldest
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_oldest))
        else $error("window ages lost their single oldest entry");

    // the cell row stays sorted
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order)
        else $error("cell row out of order");

    // a beat taken into an empty queue is offered at the next edge
    a_empty_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && w_push) |=> o_out_valid)
        else $error("result not presented after beat accepted");

    // a full queue drains by one on a pop and never overfills
    a_full_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && w_pop) |=> (r_cnt == 2'd1))
        else $error("queue count wrong after pop from full");

endmodule

[rtl/trmf_meas.sv]
module trmf_meas (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [trmf_pkg::FACTOR_W-1:0]    i_cfg_wdata,
    input  logic                             i_take,
    input  logic                             i_tacho_edge,
    input  logic                             i_period_end,
    input  logic                             i_read_ack,
    output logic [trmf_pkg::RPM_W-1:0]       o_rpm,
    output trmf_pkg::t_status                o_next
);

    logic [trmf_pkg::FACTOR_W-1:0] r_factor;
    logic [trmf_pkg::RPM_W-1:0]    r_count;
    logic [trmf_pkg::RPM_W-1:0]    r_latest;
    logic                          r_stall;
    logic                          r_fresh;

    logic [trmf_pkg::RPM_W-1:0]    n_count;
    logic [trmf_pkg::PROD_W-1:0]   w_prod;
    logic [trmf_pkg::RPM_W-1:0]    w_rpm;

    assign w_prod = trmf_pkg::PROD_W'(r_count) * trmf_pkg::PROD_W'(r_factor);
    assign w_rpm  = (w_prod[trmf_pkg::PROD_W-1:trmf_pkg::RPM_W] != '0)
                    ? trmf_pkg::RPM_MAX : w_prod[trmf_pkg::RPM_W-1:0];
    assign o_rpm  = w_rpm;

    always_comb begin
        o_next.latest  = i_period_end ? w_rpm : r_latest;
        o_next.stalled = i_period_end ? (r_count == '0) : r_stall;
        // ack first, so a period end in the same beat leaves fresh set
        o_next.fresh   = i_period_end | (r_fresh & ~i_read_ack);
        if (i_period_end) begin
            n_count = {{(trmf_pkg::RPM_W-1){1'b0}}, i_tacho_edge};
        end else if (i_tacho_edge && r_count != trmf_pkg::CNT_MAX) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= trmf_pkg::FACTOR_RST;
            r_count  <= '0;
            r_latest <= '0;
            r_stall  <= 1'b0;
            r_fresh  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_factor <= i_cfg_wdata;
            end
            if (i_take) begin
                r_count  <= n_count;
                r_latest <= o_next.latest;
                r_stall  <= o_next.stalled;
                r_fresh  <= o_next.fresh;
            end
        end
    end

endmodule

[rtl/trmf_cell.sv]
module trmf_cell #(
    parameter int WINDOW = 5,
    parameter int AGE_W  = 3,
    parameter int INDEX  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ins,
    input  logic [trmf_pkg::RPM_W-1:0]  i_x,
    input  trmf_pkg::t_link             i_link,
    input  logic [trmf_pkg::RPM_W-1:0]  i_left_u_value,
    input  logic [AGE_W-1:0]            i_left_u_age,
    input  logic [trmf_pkg::RPM_W-1:0]  i_right_value,
    input  logic [AGE_W-1:0]            i_right_age,
    output trmf_pkg::t_link             o_link,
    output logic [trmf_pkg::RPM_W-1:0]  o_u_value,
    output logic [AGE_W-1:0]            o_u_age,
    output logic [trmf_pkg::RPM_W-1:0]  o_value,
    output logic [AGE_W-1:0]            o_age,
    output logic [trmf_pkg::RPM_W-1:0]  o_n_value
);

    localparam bit LAST = (INDEX == WINDOW - 1);

    logic [trmf_pkg::RPM_W-1:0] r_value;
    logic [AGE_W-1:0]           r_age;
    logic [trmf_pkg::RPM_W-1:0] n_value;
    logic [AGE_W-1:0]           n_age;
    logic                       w_rm_here;
    logic                       w_le;

    // once the oldest entry is at or left of here, the survivors shift left
    assign w_rm_here = i_link.rm_seen | (r_age == AGE_W'(WINDOW - 1));
    assign o_u_value = w_rm_here ? i_right_value : r_value;
    assign o_u_age   = w_rm_here ? i_right_age : r_age;
    assign w_le      = LAST ? 1'b0 : (o_u_value <= i_x);

    assign o_link.le      = w_le;
    assign o_link.rm_seen = w_rm_here;

    always_comb begin
        if (w_le) begin
            n_value = o_u_value;
            n_age   = o_u_age + 1'b1;
        end else if (i_link.le) begin
            n_value = i_x;
            n_age   = '0;
        end else begin
            n_value = i_left_u_value;
            n_age   = i_left_u_age + 1'b1;
        end
    end

    assign o_value   = r_value;
    assign o_age     = r_age;
    assign o_n_value = i_ins ? n_value : r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= AGE_W'(INDEX);
        end else if (i_ins) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule
